>>> hdl/bpdf_pkg.sv
// Package for the beacon propagation delay forwarder: request and result types,
// mode and kind codes, and the widths of the distance datapath. No dependencies.
package bpdf_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int SUM_W      = 2 * DIFF_W + 2;
  localparam int ROOT_W     = DIFF_W + 1;
  localparam int REM_W      = ROOT_W + 3;
  localparam int RANGE_W    = 25;
  localparam int COUNT_W    = 26;
  localparam int TPT_W      = 16;
  localparam int CNT_W      = $clog2(ROOT_W);
  localparam int DATA_W     = 32;

  localparam logic [TPT_W-1:0] TPT_RESET = 16'd3430;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_ARRIVE = 2'd1;
  localparam logic [1:0] MODE_GEOM   = 2'd2;

  localparam logic KIND_FWD   = 1'b0;
  localparam logic KIND_RANGE = 1'b1;

  localparam logic REG_TPT = 1'b0;

  typedef struct packed {
    logic [1:0]                   mode;
    logic [2:0]                   beacon;
    logic [31:0]                  stamp;
    logic signed [COORD_BITS-1:0] drone_x;
    logic signed [COORD_BITS-1:0] drone_y;
    logic signed [COORD_BITS-1:0] drone_z;
    logic signed [COORD_BITS-1:0] anchor_x;
    logic signed [COORD_BITS-1:0] anchor_y;
    logic signed [COORD_BITS-1:0] anchor_z;
  } req_t;

  typedef struct packed {
    logic               kind;
    logic [2:0]         beacon_out;
    logic [31:0]        stamp_out;
    logic [RANGE_W-1:0] range_mm;
    logic               last;
  } res_t;

endpackage

>>> hdl/beacon_propagation_delay_forwarder_unit.sv
// Beacon propagation delay forwarder: per-beacon travel emulation with one shared
// multiplier and a bit-serial square root. Depends on bpdf_pkg.
//
//   channel  signals                               direction
//   in       in_valid_i / in_ready_o / in_i        request (req_t)
//   out      out_valid_o / out_ready_i / out_o     result  (res_t)
//   cfg      psel penable pwrite paddr ...             APB register travel_per_tick
//
// Arrival and ignored requests are handled as they are accepted. A geometry request
// passes through the shared multiplier, ROOT_W (25) square-root steps and an output step.
// A tick walks the beacons one per cycle, save where a full output register holds it.
// Ready is low while a request is in work; a full output register stalls the walk
// or the result step. Reset clears flags, counters, ranges and the output valid flag.
module beacon_propagation_delay_forwarder_unit
  import bpdf_pkg::*;
#(
  parameter int BEACONS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_t              in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output res_t              out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W = (BEACONS > 1) ? $clog2(BEACONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BEACONS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_GOUT = 3'd3;
  localparam logic [2:0] ST_WALK = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  req_t               req_q;
  logic [IDX_W-1:0]   idx_q;
  logic [IDX_W-1:0]   walk_q, walk_d;
  logic [SQ_W-1:0]    prod_q;
  logic [SUM_W-1:0]   acc_q, acc_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic [BEACONS-1:0] fwd_q;
  logic [TPT_W-1:0]   tpt_q;
  logic               out_valid_q, out_valid_d;
  res_t               out_q, out_d;

  logic [RANGE_W-1:0] range_q [BEACONS];
  logic [COUNT_W-1:0] count_q [BEACONS];
  logic [31:0]        stamp_q [BEACONS];
  logic [BEACONS-1:0] recv_q;
  logic [BEACONS-1:0] sent_q;

  logic               accept;
  logic               out_free;
  logic               bcn_ok;
  logic [2:0]         bcn_m1;
  logic [IDX_W-1:0]   bcn_idx;
  logic [BEACONS-1:0] fwd_now;
  logic [BEACONS-1:0] later;
  logic               walk_go;
  logic               geo_wr;
  logic               arr_wr;
  logic               cfg_wr;
  logic signed [COORD_BITS-1:0] sel_d, sel_a;
  logic signed [COORD_BITS:0]   diff;
  logic [DIFF_W-1:0]  diff_abs;
  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign bcn_m1  = in_i.beacon - 3'd1;
  assign bcn_idx = IDX_W'(bcn_m1);
  assign bcn_ok  = (in_i.beacon != 3'd0) && (int'(in_i.beacon) <= BEACONS);
  assign arr_wr  = accept && (in_i.mode == MODE_ARRIVE) && bcn_ok
                   && !recv_q[bcn_idx] && !sent_q[bcn_idx];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TPT);
  assign prdata = (paddr[2] == REG_TPT) ? DATA_W'(tpt_q) : '0;

  always_comb begin
    for (int j = 0; j < BEACONS; j++) begin
      fwd_now[j] = recv_q[j] && !sent_q[j] && !(count_q[j] < COUNT_W'(range_q[j]));
      later[j]   = (j > int'(walk_q));
    end
  end

  always_comb begin
    case (cnt_q)
      CNT_W'(0): begin
        sel_d = req_q.drone_x;
        sel_a = req_q.anchor_x;
      end
      CNT_W'(1): begin
        sel_d = req_q.drone_y;
        sel_a = req_q.anchor_y;
      end
      default: begin
        sel_d = req_q.drone_z;
        sel_a = req_q.anchor_z;
      end
    endcase
    diff     = {sel_d[COORD_BITS-1], sel_d} - {sel_a[COORD_BITS-1], sel_a};
    diff_abs = diff[COORD_BITS] ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  assign rem_sh = {rem_q[REM_W-3:0], acc_q[SUM_W-1:SUM_W-2]};
  assign trial  = {REM_W'(root_q) << 2} | REM_W'(1);

  assign walk_go = (state_q == ST_WALK) && (!fwd_q[walk_q] || out_free);
  assign geo_wr  = (state_q == ST_GOUT) && out_free;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    walk_d      = walk_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    root_d      = root_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d  = '0;
          walk_d = '0;
          if (in_i.mode == MODE_TICK) begin
            state_d = ST_WALK;
          end else if (in_i.mode == MODE_GEOM && bcn_ok) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        acc_d = (cnt_q == '0) ? '0 : acc_q + SUM_W'(prod_q);
        if (cnt_q == CNT_W'(3)) begin
          cnt_d   = '0;
          rem_d   = '0;
          root_d  = '0;
          state_d = ST_SQRT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_SQRT: begin
        acc_d = acc_q << 2;
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          state_d = ST_GOUT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_GOUT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.kind       = KIND_RANGE;
          out_d.beacon_out = req_q.beacon;
          out_d.stamp_out  = '0;
          out_d.range_mm   = RANGE_W'(root_q);
          out_d.last       = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (walk_go) begin
          if (fwd_q[walk_q]) begin
            out_valid_d      = 1'b1;
            out_d.kind       = KIND_FWD;
            out_d.beacon_out = 3'(walk_q) + 3'd1;
            out_d.stamp_out  = stamp_q[walk_q];
            out_d.range_mm   = '0;
            out_d.last       = ~|(fwd_q & later);
          end
          if (walk_q == LAST_IDX) begin
            state_d = ST_IDLE;
          end else begin
            walk_d = walk_q + IDX_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
      tpt_q       <= TPT_RESET;
      fwd_q       <= '0;
      recv_q      <= '0;
      sent_q      <= '0;
      for (int j = 0; j < BEACONS; j++) begin
        range_q[j] <= '0;
        count_q[j] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        tpt_q <= pwdata[TPT_W-1:0];
      end
      if (accept) begin
        fwd_q <= fwd_now;
      end
      if (arr_wr) begin
        recv_q[bcn_idx] <= 1'b1;
      end
      if (geo_wr) begin
        range_q[idx_q] <= RANGE_W'(root_q);
      end
      if (walk_go) begin
        if (!recv_q[walk_q] && sent_q[walk_q]) begin
          sent_q[walk_q] <= 1'b0;
        end else if (recv_q[walk_q] && sent_q[walk_q]) begin
          recv_q[walk_q] <= 1'b0;
        end else if (recv_q[walk_q]) begin
          if (fwd_q[walk_q]) begin
            sent_q[walk_q]  <= 1'b1;
            count_q[walk_q] <= '0;
          end else begin
            count_q[walk_q] <= count_q[walk_q] + COUNT_W'(tpt_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    prod_q <= diff_abs * diff_abs;
    if (accept) begin
      req_q <= in_i;
      idx_q <= bcn_idx;
    end
    if (arr_wr) begin
      stamp_q[bcn_idx] <= in_i.stamp;
    end
  end

endmodule
